// ===== rtl/abps_pkg.sv =====
package abps_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // register map of the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARM_COUNT,
    CFG_ARM_LENGTH,
    CFG_KEY_COUNT,
    CFG_KEY_LENGTH,
    CFG_DISARM_COUNT,
    CFG_DISARM_LENGTH
  } cfg_idx_e;

  // ten-second chain: 190 ticks per slot, 40 slots per second, 10 seconds
  localparam logic [7:0] TenTickMax  = 8'd189;
  localparam logic [5:0] TenSlotMax  = 6'd39;
  localparam logic [3:0] TenSecMax   = 4'd9;
  // beep slot: 152 ticks times 3
  localparam logic [7:0] BeepTickMax = 8'd151;
  localparam logic [2:0] BeepSlotMax = 3'd2;

  localparam logic [7:0] ArmCountRst    = 8'd1;
  localparam logic [5:0] ArmLengthRst   = 6'd12;
  localparam logic [7:0] KeyCountRst    = 8'd5;
  localparam logic [5:0] KeyLengthRst   = 6'd7;
  localparam logic [7:0] DisarmCountRst = 8'd2;
  localparam logic [5:0] DisarmLengthRst = 6'd10;

  typedef struct packed {
    logic [7:0] arm_beep_count;
    logic [5:0] arm_beep_length;
    logic [7:0] key_beep_count;
    logic [5:0] key_beep_length;
    logic [7:0] disarm_beep_count;
    logic [5:0] disarm_beep_length;
  } cfg_t;

  typedef struct packed {
    logic protect_armed;
    logic disarm_level;
    logic arm_request;
    logic key_request;
    logic warning_restart;
    logic beep_restart;
    logic delay_restart;
  } req_t;

  typedef struct packed {
    logic beep_out;
    logic pulse_out;
    logic output_enable_strobe;
    logic power_save_strobe;
    logic arm_pending;
    logic key_pending;
  } rsp_t;

  typedef struct packed {
    logic drst;
    logic key;
    logic arm;
    logic ddone;
    logic pdone;
    logic bdone;
    logic pulse;
    logic beep;
  } marks_t;

  typedef struct packed {
    logic [7:0] tick;
    logic [5:0] slot;
    logic [3:0] sec;
  } chain_t;

  typedef struct packed {
    chain_t chain;
    logic   done;
  } chain_res_t;

  typedef struct packed {
    logic [7:0] tick;
    logic [1:0] slot;
    logic [7:0] phase;
    logic [7:0] done_cnt;
  } beep_cnt_t;

  typedef struct packed {
    beep_cnt_t cnt;
    logic      level;
    logic      done;
  } beep_res_t;

  function automatic chain_res_t ten_sec_step(chain_t c);
    chain_res_t r;
    r.chain = c;
    r.done  = 1'b0;
    r.chain.tick = c.tick + 8'd1;
    if (r.chain.tick > TenTickMax) begin
      r.chain.tick = '0;
      r.chain.slot = c.slot + 6'd1;
      if (r.chain.slot > TenSlotMax) begin
        r.chain.slot = '0;
        r.chain.sec  = c.sec + 4'd1;
        if (r.chain.sec > TenSecMax) begin
          r.chain.sec = '0;
          r.done      = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic beep_res_t beep_step(beep_cnt_t c, logic level, logic [7:0] count,
                                          logic [5:0] length);
    beep_res_t  r;
    logic [2:0] slot_inc;
    r.cnt  = c;
    r.done = 1'b0;
    r.cnt.tick = c.tick + 8'd1;
    // tone toggles every tick during the on-time
    r.level  = (c.phase < {2'b00, length}) ? ~level : 1'b0;
    slot_inc = {1'b0, c.slot} + 3'd1;
    if (r.cnt.tick > BeepTickMax) begin
      r.cnt.tick = '0;
      r.cnt.slot = slot_inc[1:0];
      if (slot_inc > BeepSlotMax) begin
        r.cnt.slot  = '0;
        r.cnt.phase = c.phase + 8'd1;
        if ({1'b0, r.cnt.phase} > {2'b00, length, 1'b0}) begin
          r.cnt.phase    = '0;
          r.cnt.done_cnt = c.done_cnt + 8'd1;
          if (r.cnt.done_cnt == count) begin
            r.cnt.done_cnt = '0;
            r.done         = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/abps_if.sv =====
interface abps_req_if;
  logic valid;
  logic ready;
  logic protect_armed;
  logic disarm_level;
  logic arm_request;
  logic key_request;
  logic warning_restart;
  logic beep_restart;
  logic delay_restart;

  modport source (
    output valid, protect_armed, disarm_level, arm_request, key_request,
           warning_restart, beep_restart, delay_restart,
    input  ready
  );
  modport sink (
    input  valid, protect_armed, disarm_level, arm_request, key_request,
           warning_restart, beep_restart, delay_restart,
    output ready
  );
endinterface

interface abps_rsp_if;
  logic valid;
  logic ready;
  logic beep_out;
  logic pulse_out;
  logic output_enable_strobe;
  logic power_save_strobe;
  logic arm_pending;
  logic key_pending;

  modport source (
    output valid, beep_out, pulse_out, output_enable_strobe, power_save_strobe,
           arm_pending, key_pending,
    input  ready
  );
  modport sink (
    input  valid, beep_out, pulse_out, output_enable_strobe, power_save_strobe,
           arm_pending, key_pending,
    output ready
  );
endinterface

interface abps_cfg_if;
  import abps_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/alarm_beep_pulse_sequencer.sv =====
// alarm buzzer and pulse-output sequencer, one timer tick per request
//
// req_i carries one tick: the protection levels and the request pulses.
// rsp_o returns one result per tick, in order: buzzer and pulse levels,
// the output-enable and power-save strobes and the pending marks.
// cfg_i writes the beep count and length of the arm, key and disarm modes;
// write it only while no tick is in flight. cfg_i is always ready.
//
// a taken request goes into the input register and, once the result register
// is free or being read, on into the result register, where its result waits
// to be taken (input register, then result register).
// throughput: one tick per cycle while the receiver takes results; the whole
// tick update is a single pass of counter and flag logic between the two registers.
// when the receiver stalls, the result register holds and the input
// register takes one more tick; req_i.ready drops only while both are full.
// reset clears all counters and marks and loads the default configuration.
module alarm_beep_pulse_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  abps_req_if.sink   req_i,
  abps_rsp_if.source rsp_o,
  abps_cfg_if.sink   cfg_i
);
  import abps_pkg::*;

  cfg_t cfg;
  req_t req_item;
  rsp_t rsp_next;

  logic in_valid_q;
  req_t in_item_q;
  logic out_valid_q, out_valid_d;
  rsp_t out_item_q;
  logic advance;

  assign req_item.protect_armed   = req_i.protect_armed;
  assign req_item.disarm_level    = req_i.disarm_level;
  assign req_item.arm_request     = req_i.arm_request;
  assign req_item.key_request     = req_i.key_request;
  assign req_item.warning_restart = req_i.warning_restart;
  assign req_item.beep_restart    = req_i.beep_restart;
  assign req_item.delay_restart   = req_i.delay_restart;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign out_valid_d = advance || (out_valid_q && !rsp_o.ready);

  abps_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  abps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_item_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) in_valid_q <= req_i.valid;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) in_item_q <= req_item;
    if (advance) out_item_q <= rsp_next;
  end

  assign rsp_o.valid                = out_valid_q;
  assign rsp_o.beep_out             = out_item_q.beep_out;
  assign rsp_o.pulse_out            = out_item_q.pulse_out;
  assign rsp_o.output_enable_strobe = out_item_q.output_enable_strobe;
  assign rsp_o.power_save_strobe    = out_item_q.power_save_strobe;
  assign rsp_o.arm_pending          = out_item_q.arm_pending;
  assign rsp_o.key_pending          = out_item_q.key_pending;

endmodule

// ===== rtl/abps_cfg_regs.sv =====
module abps_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  abps_cfg_if.sink       cfg_i,
  output abps_pkg::cfg_t cfg_o
);
  import abps_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ARM_COUNT:     cfg_d.arm_beep_count     = cfg_i.data;
        CFG_ARM_LENGTH:    cfg_d.arm_beep_length    = cfg_i.data[5:0];
        CFG_KEY_COUNT:     cfg_d.key_beep_count     = cfg_i.data;
        CFG_KEY_LENGTH:    cfg_d.key_beep_length    = cfg_i.data[5:0];
        CFG_DISARM_COUNT:  cfg_d.disarm_beep_count  = cfg_i.data;
        CFG_DISARM_LENGTH: cfg_d.disarm_beep_length = cfg_i.data[5:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_beep_count     <= ArmCountRst;
      cfg_q.arm_beep_length    <= ArmLengthRst;
      cfg_q.key_beep_count     <= KeyCountRst;
      cfg_q.key_beep_length    <= KeyLengthRst;
      cfg_q.disarm_beep_count  <= DisarmCountRst;
      cfg_q.disarm_beep_length <= DisarmLengthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/abps_core.sv =====
module abps_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  abps_pkg::req_t req_i,
  input  abps_pkg::cfg_t cfg_i,
  output abps_pkg::rsp_t rsp_o
);
  import abps_pkg::*;

  marks_t    marks_q, marks_d;
  beep_cnt_t beep_q, beep_d;
  chain_t    pulse_q, pulse_d;
  chain_t    delay_q, delay_d;

  beep_res_t  beep_r;
  chain_res_t pulse_r;
  chain_res_t delay_r;
  logic [7:0] count_sel;
  logic [5:0] length_sel;
  logic       arm_br, key_br, dis_br;
  logic       oe, ps;

  always_comb begin
    marks_d = marks_q;
    beep_d  = beep_q;
    pulse_d = pulse_q;
    delay_d = delay_q;
    oe      = 1'b0;
    ps      = 1'b0;

    // request pulses land before this tick's work
    if (req_i.arm_request)   marks_d.arm  = 1'b1;
    if (req_i.key_request)   marks_d.key  = 1'b1;
    if (req_i.delay_restart) marks_d.drst = 1'b1;
    if (req_i.warning_restart) begin
      marks_d.pdone = 1'b0;
      pulse_d       = '0;
    end
    if (req_i.beep_restart) begin
      marks_d.bdone = 1'b0;
      beep_d        = '0;
    end

    arm_br = req_i.protect_armed && marks_d.arm;
    key_br = req_i.protect_armed && !marks_d.arm && marks_d.key;
    dis_br = !req_i.protect_armed && req_i.disarm_level;

    if (!req_i.protect_armed) begin
      count_sel  = cfg_i.disarm_beep_count;
      length_sel = cfg_i.disarm_beep_length;
    end else if (marks_d.arm) begin
      count_sel  = cfg_i.arm_beep_count;
      length_sel = cfg_i.arm_beep_length;
    end else begin
      count_sel  = cfg_i.key_beep_count;
      length_sel = cfg_i.key_beep_length;
    end

    beep_r  = beep_step(beep_d, marks_d.beep, count_sel, length_sel);
    pulse_r = ten_sec_step(pulse_d);
    delay_r = ten_sec_step(marks_d.drst ? '0 : delay_d);

    if (arm_br) begin
      ps            = 1'b1;
      marks_d.pulse = 1'b0;
      if (!marks_d.bdone) begin
        beep_d        = beep_r.cnt;
        marks_d.beep  = beep_r.level;
        marks_d.bdone = beep_r.done;
      end else begin
        marks_d.arm   = 1'b0;
        marks_d.bdone = 1'b0;
      end
    end

    if (dis_br) begin
      ps            = 1'b1;
      marks_d.pulse = 1'b0;
    end

    // burst of beeps, then a ten-second pause
    if (key_br || dis_br) begin
      ps = 1'b1;
      if (!marks_d.bdone) begin
        beep_d        = beep_r.cnt;
        marks_d.beep  = beep_r.level;
        marks_d.bdone = beep_r.done;
      end else if (!marks_d.ddone) begin
        marks_d.drst  = 1'b0;
        delay_d       = delay_r.chain;
        marks_d.ddone = delay_r.done;
      end else begin
        marks_d.ddone = 1'b0;
        marks_d.bdone = 1'b0;
      end
    end

    if (key_br) begin
      if (!marks_d.pdone) begin
        if (!marks_d.pulse) oe = 1'b1;
        marks_d.pulse = 1'b1;
        pulse_d       = pulse_r.chain;
        if (pulse_r.done) begin
          marks_d.pulse = 1'b0;
          oe            = 1'b1;
        end
        marks_d.pdone = pulse_r.done;
      end else if (marks_d.bdone) begin
        marks_d.bdone = 1'b0;
        marks_d.pdone = 1'b0;
        marks_d.key   = 1'b0;
        delay_d       = '0;
      end
    end

    rsp_o.beep_out             = marks_d.beep;
    rsp_o.pulse_out            = marks_d.pulse;
    rsp_o.output_enable_strobe = oe;
    rsp_o.power_save_strobe    = ps;
    rsp_o.arm_pending          = marks_d.arm;
    rsp_o.key_pending          = marks_d.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
      beep_q  <= '0;
      pulse_q <= '0;
      delay_q <= '0;
    end else if (step_i) begin
      marks_q <= marks_d;
      beep_q  <= beep_d;
      pulse_q <= pulse_d;
      delay_q <= delay_d;
    end
  end

endmodule

// ===== rtl/abps_checker.sv =====
module abps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic beep_out_i,
  input logic pulse_out_i,
  input logic oe_strobe_i,
  input logic ps_strobe_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(beep_out_i) && $stable(pulse_out_i))
    else $error("stalled result changed");

  // a taken request leads to a valid result after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> ##1 rsp_valid_i)
    else $error("result missing after request");

  // input side backs up only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request stalled without output stall");

  // output-enable strobes happen only in the key branch, which also raises power-save
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && oe_strobe_i |-> ps_strobe_i)
    else $error("output-enable strobe outside announcement");

endmodule

bind alarm_beep_pulse_sequencer abps_checker u_abps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .beep_out_i  (rsp_o.beep_out),
  .pulse_out_i (rsp_o.pulse_out),
  .oe_strobe_i (rsp_o.output_enable_strobe),
  .ps_strobe_i (rsp_o.power_save_strobe)
);

// ===== tb/sv/alarm_beep_pulse_sequencer_test.sv =====
module alarm_beep_pulse_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import abps_pkg::*;

  localparam int unsigned GapMax      = 8;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned RandomItems = 1360;
  localparam int unsigned RandPhases  = 4;
  localparam int unsigned RareOdds    = 100;
  localparam int unsigned KeySoak     = 80;
  localparam int unsigned DisarmSoak  = 80;
  localparam int unsigned TailCycles  = 8;
  localparam longint unsigned TimeoutNs = 64'd10_000_000;

  typedef enum int {SegArm, SegKey, SegDisarm, SegNoise} seg_mode_e;

  // tick-accurate copy of the sequencer state, one expected result per tick
  class beep_pulse_tracker;
    localparam logic [7:0] SlotTicks   = 8'd189;
    localparam logic [5:0] SecondSlots = 6'd39;
    localparam logic [3:0] TenSeconds  = 4'd9;
    localparam logic [7:0] ToneTicks   = 8'd151;
    localparam logic [2:0] ToneSlots   = 3'd2;

    cfg_t        regs;
    marks_t      marks;
    chain_t      pulse_chain;
    chain_t      delay_chain;
    beep_cnt_t   tone;
    rsp_t        expected_levels[$];
    int unsigned errors;
    int unsigned ticks_checked;

    function new();
      regs = '{arm_beep_count: ArmCountRst, arm_beep_length: ArmLengthRst,
               key_beep_count: KeyCountRst, key_beep_length: KeyLengthRst,
               disarm_beep_count: DisarmCountRst, disarm_beep_length: DisarmLengthRst};
      marks = '0;
      pulse_chain = '0;
      delay_chain = '0;
      tone = '0;
      errors = 0;
      ticks_checked = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void write_reg(cfg_idx_e idx, logic [7:0] data);
      case (idx)
        CFG_ARM_COUNT:     regs.arm_beep_count     = data;
        CFG_ARM_LENGTH:    regs.arm_beep_length    = data[5:0];
        CFG_KEY_COUNT:     regs.key_beep_count     = data;
        CFG_KEY_LENGTH:    regs.key_beep_length    = data[5:0];
        CFG_DISARM_COUNT:  regs.disarm_beep_count  = data;
        CFG_DISARM_LENGTH: regs.disarm_beep_length = data[5:0];
        default: ;
      endcase
    endfunction

    function bit ten_second_step(inout chain_t c);
      c.tick = c.tick + 8'd1;
      if (c.tick > SlotTicks) begin
        c.tick = '0;
        c.slot = c.slot + 6'd1;
        if (c.slot > SecondSlots) begin
          c.slot = '0;
          c.sec  = c.sec + 4'd1;
          if (c.sec > TenSeconds) begin
            c.sec = '0;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function bit delay_advance();
      if (marks.drst) begin
        marks.drst  = 1'b0;
        marks.ddone = 1'b0;
        delay_chain = '0;
      end
      return ten_second_step(delay_chain);
    endfunction

    function bit pulse_advance(inout bit strobe);
      if (!marks.pulse) strobe = 1'b1;
      marks.pulse = 1'b1;
      if (ten_second_step(pulse_chain)) begin
        marks.pulse = 1'b0;
        strobe = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit tone_advance(logic [7:0] count, logic [5:0] length);
      logic [2:0] next_slot;
      tone.tick = tone.tick + 8'd1;
      if (tone.phase < {2'b00, length}) marks.beep = ~marks.beep;
      else marks.beep = 1'b0;
      if (tone.tick > ToneTicks) begin
        tone.tick = '0;
        next_slot = {1'b0, tone.slot} + 3'd1;
        tone.slot = next_slot[1:0];
        if (next_slot > ToneSlots) begin
          tone.slot  = '0;
          tone.phase = tone.phase + 8'd1;
          // beep on for length phases, silent until 2*length+1 phases have passed
          if ({1'b0, tone.phase} > {2'b00, length, 1'b0}) begin
            tone.phase    = '0;
            tone.done_cnt = tone.done_cnt + 8'd1;
            if (tone.done_cnt == count) begin
              tone.done_cnt = '0;
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void burst_advance(logic [7:0] count, logic [5:0] length);
      if (!marks.bdone) begin
        marks.bdone = tone_advance(count, length);
      end else if (!marks.ddone) begin
        marks.ddone = delay_advance();
      end else begin
        marks.ddone = 1'b0;
        marks.bdone = 1'b0;
      end
    endfunction

    function rsp_t advance_tick(req_t r);
      bit   oe;
      bit   ps;
      rsp_t res;
      oe = 1'b0;
      ps = 1'b0;
      if (r.arm_request) marks.arm = 1'b1;
      if (r.key_request) marks.key = 1'b1;
      if (r.delay_restart) marks.drst = 1'b1;
      if (r.warning_restart) begin
        marks.pdone = 1'b0;
        pulse_chain = '0;
      end
      if (r.beep_restart) begin
        marks.bdone = 1'b0;
        tone = '0;
      end
      if (r.protect_armed) begin
        if (marks.arm) begin
          ps = 1'b1;
          marks.pulse = 1'b0;
          if (!marks.bdone) begin
            marks.bdone = tone_advance(regs.arm_beep_count, regs.arm_beep_length);
          end else begin
            marks.arm   = 1'b0;
            marks.bdone = 1'b0;
          end
        end else if (marks.key) begin
          ps = 1'b1;
          burst_advance(regs.key_beep_count, regs.key_beep_length);
          if (!marks.pdone) begin
            marks.pdone = pulse_advance(oe);
          end else if (marks.bdone) begin
            marks.bdone = 1'b0;
            marks.pdone = 1'b0;
            marks.key   = 1'b0;
            delay_chain = '0;
          end
        end
      end else if (r.disarm_level) begin
        ps = 1'b1;
        marks.pulse = 1'b0;
        burst_advance(regs.disarm_beep_count, regs.disarm_beep_length);
      end
      res.beep_out             = marks.beep;
      res.pulse_out            = marks.pulse;
      res.output_enable_strobe = oe;
      res.power_save_strobe    = ps;
      res.arm_pending          = marks.arm;
      res.key_pending          = marks.key;
      return res;
    endfunction

    function void note_tick(req_t r);
      expected_levels.push_back(advance_tick(r));
    endfunction

    task check_levels(rsp_t got);
      rsp_t  want;
      string names[6];
      names = '{"beep_out", "pulse_out", "output_enable_strobe", "power_save_strobe",
                "arm_pending", "key_pending"};
      ticks_checked++;
      if (expected_levels.size() == 0) begin
        report($sformatf("result %0d arrived with no tick waiting", ticks_checked));
        return;
      end
      want = expected_levels.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[5-i] !== want[5-i])
          report($sformatf("tick %0d %s got %b want %b", ticks_checked, names[i],
                           got[5-i], want[5-i]));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;

  abps_req_if req_if ();
  abps_rsp_if rsp_if ();
  abps_cfg_if cfg_if ();

  beep_pulse_tracker tracker;

  alarm_beep_pulse_sequencer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk = ~clk;

  function automatic bit rare();
    return $urandom_range(0, RareOdds - 1) == 0;
  endfunction

  task automatic send_tick(req_t r);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, GapMax);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.protect_armed   <= r.protect_armed;
    req_if.disarm_level    <= r.disarm_level;
    req_if.arm_request     <= r.arm_request;
    req_if.key_request     <= r.key_request;
    req_if.warning_restart <= r.warning_restart;
    req_if.beep_restart    <= r.beep_restart;
    req_if.delay_restart   <= r.delay_restart;
    do @(posedge clk); while (!req_if.ready);
    tracker.note_tick(r);
  endtask

  task automatic drain_results();
    rsp_t        got;
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    forever begin
      // two long hold-offs so the block fills up and drops req ready
      if (taken == 400 || taken == 1100) stall = HoldCycles;
      else if (steady) stall = 0;
      else stall = $urandom_range(0, GapMax);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      got.beep_out             = rsp_if.beep_out;
      got.pulse_out            = rsp_if.pulse_out;
      got.output_enable_strobe = rsp_if.output_enable_strobe;
      got.power_save_strobe    = rsp_if.power_save_strobe;
      got.arm_pending          = rsp_if.arm_pending;
      got.key_pending          = rsp_if.key_pending;
      tracker.check_levels(got);
      taken++;
    end
  endtask

  task automatic settle();
    while (tracker.expected_levels.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    cfg_idx_e   order[6];
    logic [7:0] data[6];
    order = '{CFG_ARM_COUNT, CFG_ARM_LENGTH, CFG_KEY_COUNT, CFG_KEY_LENGTH,
              CFG_DISARM_COUNT, CFG_DISARM_LENGTH};
    // the unused upper data bits of the length writes get random values
    data = '{c.arm_beep_count, {2'($urandom), c.arm_beep_length},
             c.key_beep_count, {2'($urandom), c.key_beep_length},
             c.disarm_beep_count, {2'($urandom), c.disarm_beep_length}};
    for (int i = 0; i < 6; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[i];
      cfg_if.data  <= data[i];
      do @(posedge clk); while (!cfg_if.ready);
      tracker.write_reg(order[i], data[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_segments(int unsigned count);
    int unsigned sent;
    int unsigned seg_len;
    seg_mode_e   mode;
    logic        side_level;
    logic [6:0]  bits;
    req_t        r;
    sent = 0;
    while (sent < count) begin
      mode       = seg_mode_e'($urandom_range(0, 3));
      seg_len    = $urandom_range(20, 300);
      side_level = 1'($urandom);
      steady     = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < seg_len && sent < count; i++) begin
        bits = 7'($urandom);
        r = req_t'(bits);
        if (mode != SegNoise) begin
          r.protect_armed   = (mode != SegDisarm);
          r.disarm_level    = (mode == SegDisarm) ? 1'b1 : side_level;
          r.arm_request     = (mode == SegArm && i == 0) || rare();
          r.key_request     = (mode == SegKey && i == 0) || rare();
          r.warning_restart = rare();
          r.beep_restart    = rare();
          r.delay_restart   = rare();
        end
        send_tick(r);
        sent++;
      end
    end
    steady = 1'b0;
    req_if.valid <= 1'b0;
  endtask

  task automatic soak(req_t first, req_t rest, int unsigned count);
    steady = 1'b1;
    send_tick(first);
    repeat (count - 1) send_tick(rest);
    steady = 1'b0;
    req_if.valid <= 1'b0;
  endtask

  initial begin
    req_t       directed[$];
    cfg_t       c;
    logic [6:0] one_hot;
    rst_n                  <= 1'b0;
    steady                 = 1'b0;
    req_if.valid           <= 1'b0;
    req_if.protect_armed   <= 1'b0;
    req_if.disarm_level    <= 1'b0;
    req_if.arm_request     <= 1'b0;
    req_if.key_request     <= 1'b0;
    req_if.warning_restart <= 1'b0;
    req_if.beep_restart    <= 1'b0;
    req_if.delay_restart   <= 1'b0;
    rsp_if.ready           <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= CFG_ARM_COUNT;
    cfg_if.data            <= '0;
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    // field extremes, each field alone, then the mode transitions
    directed.push_back(req_t'(7'h00));
    directed.push_back(req_t'(7'h7f));
    for (int b = 0; b < 7; b++) begin
      one_hot = 7'h01 << b;
      directed.push_back(req_t'(one_hot));
    end
    // both pending: arm announcement wins
    directed.push_back(req_t'{protect_armed: 1'b1, arm_request: 1'b1, key_request: 1'b1,
                              default: 1'b0});
    directed.push_back(req_t'{protect_armed: 1'b1, default: 1'b0});
    directed.push_back(req_t'{protect_armed: 1'b1, beep_restart: 1'b1, default: 1'b0});
    directed.push_back(req_t'{protect_armed: 1'b1, key_request: 1'b1, default: 1'b0});
    directed.push_back(req_t'{protect_armed: 1'b1, warning_restart: 1'b1, default: 1'b0});
    directed.push_back(req_t'{disarm_level: 1'b1, default: 1'b0});
    directed.push_back(req_t'{disarm_level: 1'b1, delay_restart: 1'b1, default: 1'b0});
    directed.push_back(req_t'{disarm_level: 1'b1, beep_restart: 1'b1, default: 1'b0});
    directed.push_back(req_t'{protect_armed: 1'b1, disarm_level: 1'b1, default: 1'b0});
    directed.push_back(req_t'(7'h00));
    foreach (directed[i]) send_tick(directed[i]);
    req_if.valid <= 1'b0;
    settle();

    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: c = '0;
        1: c = '{arm_beep_count: 8'hff, arm_beep_length: 6'h3f, key_beep_count: 8'hff,
                 key_beep_length: 6'h3f, disarm_beep_count: 8'hff,
                 disarm_beep_length: 6'h3f};
        2: c = '{arm_beep_count: 8'd1, arm_beep_length: 6'd1, key_beep_count: 8'd1,
                 key_beep_length: 6'd1, disarm_beep_count: 8'd1, disarm_beep_length: 6'd1};
        default: c = '{arm_beep_count: 8'($urandom_range(0, 3)),
                       arm_beep_length: 6'($urandom_range(0, 2)),
                       key_beep_count: 8'($urandom_range(0, 3)),
                       key_beep_length: 6'($urandom_range(0, 2)),
                       disarm_beep_count: 8'($urandom_range(0, 3)),
                       disarm_beep_length: 6'($urandom_range(0, 2))};
      endcase
      load_config(c);
      random_segments(RandomItems / RandPhases);
      settle();
    end

    // back-to-back runs through the arm and key branches, then the disarm branch
    c = '{arm_beep_count: 8'd1, arm_beep_length: 6'd0, key_beep_count: 8'd1,
          key_beep_length: 6'd1, disarm_beep_count: 8'd2, disarm_beep_length: 6'd1};
    load_config(c);
    soak(req_t'{protect_armed: 1'b1, arm_request: 1'b1, key_request: 1'b1,
                beep_restart: 1'b1, warning_restart: 1'b1, default: 1'b0},
         req_t'{protect_armed: 1'b1, default: 1'b0}, KeySoak);
    settle();
    soak(req_t'{disarm_level: 1'b1, beep_restart: 1'b1, delay_restart: 1'b1,
                default: 1'b0},
         req_t'{disarm_level: 1'b1, default: 1'b0}, DisarmSoak);
    settle();

    if (tracker.errors == 0 && tracker.expected_levels.size() == 0) begin
      $display("alarm_beep_pulse_sequencer_test passed");
    end else begin
      $display("alarm_beep_pulse_sequencer_test failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("alarm_beep_pulse_sequencer_test failed");
    $finish;
  end

endmodule
